>>> design/aci_pkg.sv
// aci_pkg: shared types and constants for the adc calibration table block
// widths, request codes, search sequencer states and inter-module structs
// no dependencies

package aci_pkg;

	localparam int ADC_BITS      = 12;
	localparam int FRACTION_BITS = 8;
	localparam int IDX_W         = 8;
	localparam int TABLE_POINTS  = 1 << IDX_W;
	localparam int DAC_W         = 16;
	localparam int QUOT_W        = FRACTION_BITS + 1;
	localparam int DIV_STEPS     = QUOT_W;

	typedef logic [ADC_BITS-1:0] code_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [DAC_W-1:0]    dac_t;
	typedef logic [QUOT_W-1:0]   quot_t;

	localparam idx_t LAST_IDX = idx_t'(TABLE_POINTS - 1);

	localparam logic REQ_POINT   = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	typedef enum logic [2:0] {
		SR_IDLE,
		SR_FIRST,
		SR_LAST,
		SR_BIN,
		SR_LIN,
		SR_PREP,
		SR_DIV
	} srch_state_t;

	typedef struct packed {
		logic  start;
		logic  mono;
		code_t code;
	} srch_req_t;

	typedef struct packed {
		logic done;
		dac_t dac;
	} srch_res_t;

endpackage

>>> design/aci_table_ram.sv
// aci_table_ram: 256 x 12 calibration table, one write port, one read port
// read data registered; uses aci_pkg

module aci_table_ram (
	input  logic           clk,
	input  logic           wr_en,
	input  aci_pkg::idx_t  wr_addr,
	input  aci_pkg::code_t wr_data,
	input  aci_pkg::idx_t  rd_addr,
	output aci_pkg::code_t rd_data
);

	aci_pkg::code_t mem [aci_pkg::TABLE_POINTS];
	aci_pkg::code_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/aci_divider.sv
// aci_divider: restoring divider, one quotient bit per cycle
// gives floor((num << FRACTION_BITS) / den) for num <= den; uses aci_pkg

module aci_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  aci_pkg::code_t num,
	input  aci_pkg::code_t den,
	output logic           done,
	output aci_pkg::quot_t quot
);

	localparam int CNT_W = $clog2(aci_pkg::DIV_STEPS + 1);

	logic [CNT_W-1:0]           cnt_q;
	logic                       done_q;
	logic [aci_pkg::ADC_BITS:0] rem_q;
	aci_pkg::code_t             den_q;
	aci_pkg::quot_t             quot_q;

	logic                       ge;
	logic [aci_pkg::ADC_BITS:0] diff;
	logic [aci_pkg::ADC_BITS:0] rem_sel;

	assign ge      = rem_q >= {1'b0, den_q};
	assign diff    = rem_q - {1'b0, den_q};
	assign rem_sel = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(aci_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			// first step yields the integer bit, the rest the fraction
			rem_q  <= {rem_sel[aci_pkg::ADC_BITS-1:0], 1'b0};
			quot_q <= {quot_q[aci_pkg::QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> design/aci_search.sv
// aci_search: lookup sequencer over the table ram, then interpolation
// binary search on a table filled in order, linear scan otherwise
// uses aci_pkg and aci_divider

module aci_search (
	input  logic               clk,
	input  logic               arst_n,
	input  aci_pkg::srch_req_t req,
	output aci_pkg::srch_res_t res,
	output aci_pkg::idx_t      rd_addr,
	input  aci_pkg::code_t     rd_data
);

	aci_pkg::srch_state_t state_q, state_d;
	aci_pkg::code_t       code_q, code_d;
	logic                 mono_q, mono_d;
	aci_pkg::idx_t        addr_q, addr_d;
	aci_pkg::idx_t        lo_idx_q, lo_idx_d;
	aci_pkg::idx_t        hi_idx_q, hi_idx_d;
	aci_pkg::code_t       lo_val_q, lo_val_d;
	aci_pkg::code_t       hi_val_q, hi_val_d;

	logic                 div_start;
	logic                 div_done;
	aci_pkg::quot_t       div_quot;
	aci_pkg::code_t       div_num;
	aci_pkg::code_t       div_den;

	logic                 take_hi;
	aci_pkg::idx_t        nlo;
	aci_pkg::idx_t        nhi;
	aci_pkg::idx_t        span;
	logic [aci_pkg::IDX_W:0] mid_sum;
	aci_pkg::idx_t        base;

	assign take_hi = code_q <= rd_data;
	assign nlo     = take_hi ? lo_idx_q : addr_q;
	assign nhi     = take_hi ? addr_q : hi_idx_q;
	assign span    = nhi - nlo;
	assign mid_sum = {1'b0, nlo} + {1'b0, nhi};
	assign base    = hi_idx_q - 1'b1;
	assign div_num = code_q - lo_val_q;
	assign div_den = hi_val_q - lo_val_q;

	aci_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aci_pkg::SR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q   <= code_d;
		mono_q   <= mono_d;
		addr_q   <= addr_d;
		lo_idx_q <= lo_idx_d;
		hi_idx_q <= hi_idx_d;
		lo_val_q <= lo_val_d;
		hi_val_q <= hi_val_d;
	end

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		mono_d    = mono_q;
		addr_d    = addr_q;
		lo_idx_d  = lo_idx_q;
		hi_idx_d  = hi_idx_q;
		lo_val_d  = lo_val_q;
		hi_val_d  = hi_val_q;
		rd_addr   = '0;
		div_start = 1'b0;
		res.done  = 1'b0;
		res.dac   = '0;
		case (state_q)
			aci_pkg::SR_IDLE: begin
				if (req.start) begin
					code_d  = req.code;
					mono_d  = req.mono;
					state_d = aci_pkg::SR_FIRST;
				end
			end
			aci_pkg::SR_FIRST: begin
				// rd_data holds entry 0
				if (code_q <= rd_data) begin
					res.done = 1'b1;
					state_d  = aci_pkg::SR_IDLE;
				end else begin
					lo_val_d = rd_data;
					rd_addr  = aci_pkg::LAST_IDX;
					state_d  = aci_pkg::SR_LAST;
				end
			end
			aci_pkg::SR_LAST: begin
				if (code_q >= rd_data) begin
					res.done = 1'b1;
					res.dac  = {aci_pkg::LAST_IDX, {aci_pkg::FRACTION_BITS{1'b0}}};
					state_d  = aci_pkg::SR_IDLE;
				end else begin
					hi_val_d = rd_data;
					if (mono_q) begin
						lo_idx_d = '0;
						hi_idx_d = aci_pkg::LAST_IDX;
						addr_d   = aci_pkg::LAST_IDX >> 1;
						rd_addr  = aci_pkg::LAST_IDX >> 1;
						state_d  = aci_pkg::SR_BIN;
					end else begin
						addr_d  = aci_pkg::idx_t'(1);
						rd_addr = aci_pkg::idx_t'(1);
						state_d = aci_pkg::SR_LIN;
					end
				end
			end
			aci_pkg::SR_BIN: begin
				// invariant: code above entry lo, at or below entry hi
				lo_idx_d = nlo;
				hi_idx_d = nhi;
				if (take_hi) begin
					hi_val_d = rd_data;
				end else begin
					lo_val_d = rd_data;
				end
				if (span > aci_pkg::idx_t'(1)) begin
					addr_d  = mid_sum[aci_pkg::IDX_W:1];
					rd_addr = mid_sum[aci_pkg::IDX_W:1];
				end else begin
					state_d = aci_pkg::SR_PREP;
				end
			end
			aci_pkg::SR_LIN: begin
				if (take_hi) begin
					hi_val_d = rd_data;
					hi_idx_d = addr_q;
					state_d  = aci_pkg::SR_PREP;
				end else begin
					lo_val_d = rd_data;
					addr_d   = addr_q + 1'b1;
					rd_addr  = addr_q + 1'b1;
				end
			end
			aci_pkg::SR_PREP: begin
				if (hi_val_q <= lo_val_q) begin
					res.done = 1'b1;
					res.dac  = {hi_idx_q, {aci_pkg::FRACTION_BITS{1'b0}}};
					state_d  = aci_pkg::SR_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = aci_pkg::SR_DIV;
				end
			end
			aci_pkg::SR_DIV: begin
				if (div_done) begin
					res.done = 1'b1;
					res.dac  = {base, {aci_pkg::FRACTION_BITS{1'b0}}}
						+ aci_pkg::dac_t'(div_quot);
					state_d  = aci_pkg::SR_IDLE;
				end
			end
			default: begin
				state_d = aci_pkg::SR_IDLE;
			end
		endcase
		if (state_q == aci_pkg::SR_IDLE) begin
			rd_addr = '0;
		end
	end

endmodule

>>> design/adc_calibration_table_inverse_interp.sv
// adc_calibration_table_inverse_interp: monotonic adc calibration table with
// inverse lookup and linear interpolation; uses aci_pkg, aci_table_ram, aci_search
//
//   channel   direction   handshake             payload
//   in        input       in_valid / in_stall   req_type, point_index, adc_code
//   out       output      out_valid / out_stall result_valid, dac_equivalent,
//                                               stored_code, was_clamped
//
// one item in flight; a calibration point or uncalibrated conversion skips the search
// a conversion on a table swept in order reads entry 0 and the last entry, then runs an
// 8-step binary search and the 9-step divider; on any other table it does a linear scan,
// one ram read a cycle; a code at or beyond an end entry skips the search and divider
// a finished result waits in the output register while the next item is taken
// reset clears control state only; table entries are undefined until written

module adc_calibration_table_inverse_interp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           req_type,
	input  aci_pkg::idx_t  point_index,
	input  aci_pkg::code_t adc_code,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           result_valid,
	output aci_pkg::dac_t  dac_equivalent,
	output aci_pkg::code_t stored_code,
	output logic           was_clamped
);

	// calibration state
	aci_pkg::code_t prev_code_q;
	logic           table_valid_q;
	logic           sweep_active_q;
	logic           mono_q;
	aci_pkg::idx_t  last_idx_q;

	// item being worked on
	logic           work_q;
	logic           wdone_q;
	logic           res_valid_q;
	aci_pkg::dac_t  res_dac_q;
	aci_pkg::code_t res_stored_q;
	logic           res_clamped_q;

	// output register
	logic           out_valid_q;
	logic           out_rv_q;
	aci_pkg::dac_t  out_dac_q;
	aci_pkg::code_t out_stored_q;
	logic           out_clamped_q;

	logic               accept;
	logic               is_cal;
	logic               cal_ok;
	logic               clamp;
	aci_pkg::code_t     cal_code;
	logic               ram_we;
	logic               move;
	aci_pkg::srch_req_t srch_req;
	aci_pkg::srch_res_t srch_res;
	aci_pkg::idx_t      rd_addr;
	aci_pkg::code_t     rd_data;

	assign in_stall = work_q;
	assign accept   = in_valid && !work_q;
	assign is_cal   = req_type == aci_pkg::REQ_POINT;
	assign cal_ok   = (point_index == '0) || sweep_active_q;
	assign clamp    = (point_index != '0) && (adc_code < prev_code_q);
	assign cal_code = clamp ? prev_code_q : adc_code;
	assign ram_we   = accept && is_cal && cal_ok;
	assign move     = work_q && wdone_q && (!out_valid_q || !out_stall);

	assign srch_req.start = accept && !is_cal && table_valid_q && !sweep_active_q;
	assign srch_req.mono  = mono_q;
	assign srch_req.code  = adc_code;

	aci_table_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (point_index),
		.wr_data (cal_code),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	aci_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (srch_req),
		.res     (srch_res),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q    <= '0;
			table_valid_q  <= 1'b0;
			sweep_active_q <= 1'b0;
			mono_q         <= 1'b0;
			last_idx_q     <= '0;
		end else if (ram_we) begin
			prev_code_q <= cal_code;
			last_idx_q  <= point_index;
			if (point_index == '0) begin
				sweep_active_q <= 1'b1;
				table_valid_q  <= 1'b0;
				mono_q         <= 1'b1;
			end else if (point_index != last_idx_q + 1'b1) begin
				// out-of-order sweep, table may not be monotonic
				mono_q <= 1'b0;
			end
			if (point_index == aci_pkg::LAST_IDX) begin
				table_valid_q  <= 1'b1;
				sweep_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q      <= 1'b0;
			wdone_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				work_q  <= 1'b1;
				wdone_q <= !srch_req.start;
			end else if (move) begin
				work_q <= 1'b0;
			end
			if (srch_res.done) begin
				wdone_q <= 1'b1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_valid_q   <= srch_req.start;
			res_dac_q     <= '0;
			res_stored_q  <= ram_we ? cal_code : '0;
			res_clamped_q <= ram_we && clamp;
		end else if (srch_res.done) begin
			res_dac_q <= srch_res.dac;
		end
		if (move) begin
			out_rv_q      <= res_valid_q;
			out_dac_q     <= res_dac_q;
			out_stored_q  <= res_stored_q;
			out_clamped_q <= res_clamped_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_valid   = out_rv_q;
	assign dac_equivalent = out_dac_q;
	assign stored_code    = out_stored_q;
	assign was_clamped    = out_clamped_q;

`ifndef SYNTHESIS
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (work_q && !wdone_q))
		else $error("search finished with no conversion outstanding");

	a_valid_not_sweeping: assert property (@(posedge clk) disable iff (!arst_n)
		!(table_valid_q && sweep_active_q))
		else $error("table valid during a sweep");

	a_conv_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rv_q) |-> (out_stored_q == '0 && !out_clamped_q))
		else $error("conversion result carries calibration fields");

	a_clamp_holds_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && clamp) |=> (prev_code_q == $past(prev_code_q)))
		else $error("clamped point changed the previous code");
`endif

endmodule
